@@ hdl/acf_pkg.sv @@
// Shared types and constants for the audio convolution FIR block.
// No dependencies; every other file in hdl/ imports this package.
package acf_pkg;

  localparam int ACF_MAX_TAPS = 1024;

  localparam int SAMPLE_W    = 16;
  localparam int TAP_COUNT_W = 11;
  localparam int TAP_INDEX_W = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Unity tap value is 2^UNITY_SHIFT - 1.
  localparam int UNITY       = 32767;
  localparam int UNITY_SHIFT = 15;
  localparam int GAIN_FRAC   = 8;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN      = 2'd1;

  localparam logic [TAP_COUNT_W-1:0]        TAP_COUNT_RESET = 11'd1;
  localparam logic signed [CFG_DATA_W-1:0]  GAIN_RESET      = 16'sd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } acf_state_t;

  // Control that travels alongside each tap step through the term pipeline.
  typedef struct packed {
    logic beat;
    logic act;
    logic first;
    logic last;
  } acf_ctl_t;

endpackage

@@ hdl/audio_convolution_fir.sv @@
// Audio convolution FIR: convolves signed 16-bit samples with a loaded impulse
// response through one pipelined multiply-accumulate unit (acf_seq, acf_mac).
// A tap load beat is written while the block stays idle, so the next beat can follow it.
// A sample beat starts a tap walk that reads one tap and one history word per cycle;
// the term pipeline and output hand-off follow, and the next input beat is taken
// once the sum has moved into the output register, which waits on m_tready.
// A tap_count of zero still runs one empty step; counts above MAX_TAPS walk MAX_TAPS
// taps. Unwritten history is masked by a fill count cleared at reset, so there is
// no clearing pass. Taps must be loaded before they are used.
module audio_convolution_fir #(
  parameter int MAX_TAPS = acf_pkg::ACF_MAX_TAPS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tap_index [9:0], tap_value [25:10], sample_in [41:26], zero [47:42]
  input  logic [47:0]                         s_tdata,
  // req_type [0]
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // sample_out [15:0]
  output logic [15:0]                         m_tdata,
  input  logic                                cfg_we,
  input  logic [acf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [acf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import acf_pkg::*;

  logic [TAP_COUNT_W-1:0]     tap_count;
  logic signed [SAMPLE_W-1:0] gain_q8_8;
  logic                       in_accept;
  logic                       idle;
  logic                       res_valid;
  logic                       res_take;
  logic signed [SAMPLE_W-1:0] res;
  logic signed [SAMPLE_W-1:0] x_rd;
  logic signed [SAMPLE_W-1:0] tap_rd;
  acf_ctl_t                   ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
      gain_q8_8 <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAP_COUNT: tap_count <= cfg_data[TAP_COUNT_W-1:0];
        CFG_GAIN:      gain_q8_8 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_tready  = idle;
  assign in_accept = s_tvalid && s_tready;
  assign res_take  = res_valid && (!m_tvalid || m_tready);

  acf_seq #(
    .MAX_TAPS(MAX_TAPS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .req_type  (s_tuser[0]),
    .tap_index (s_tdata[9:0]),
    .tap_value (s_tdata[25:10]),
    .sample_in (s_tdata[41:26]),
    .tap_count (tap_count),
    .res_take  (res_take),
    .idle      (idle),
    .x_rd      (x_rd),
    .tap_rd    (tap_rd),
    .ctl       (ctl)
  );

  acf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .x_rd      (x_rd),
    .tap_rd    (tap_rd),
    .gain      (gain_q8_8),
    .ctl_in    (ctl),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= res;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !res_valid)
    else $error("input ready while a sum is still pending");

endmodule

@@ hdl/acf_seq.sv @@
// Sequencer for the FIR: sample history and tap memories, tap walk counters.
// Depends on acf_pkg; feeds one tap step per cycle to acf_mac.
module acf_seq #(
  parameter int MAX_TAPS = acf_pkg::ACF_MAX_TAPS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_accept,
  input  logic                                    req_type,
  input  logic [acf_pkg::TAP_INDEX_W-1:0]         tap_index,
  input  logic signed [acf_pkg::SAMPLE_W-1:0]     tap_value,
  input  logic signed [acf_pkg::SAMPLE_W-1:0]     sample_in,
  input  logic [acf_pkg::TAP_COUNT_W-1:0]         tap_count,
  input  logic                                    res_take,
  output logic                                    idle,
  output logic signed [acf_pkg::SAMPLE_W-1:0]     x_rd,
  output logic signed [acf_pkg::SAMPLE_W-1:0]     tap_rd,
  output acf_pkg::acf_ctl_t                       ctl
);
  import acf_pkg::*;

  localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW  = $clog2(MAX_TAPS + 1);
  localparam int CLW = (CW > TAP_COUNT_W) ? CW : TAP_COUNT_W;
  localparam logic [AW-1:0]  LAST_ADDR = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0]  FULL      = CW'(MAX_TAPS);

  logic signed [SAMPLE_W-1:0] hist [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] taps [MAX_TAPS];

  acf_state_t      state, state_next;
  logic [AW-1:0]   ptr;
  logic [AW-1:0]   pos;
  logic [CW-1:0]   k;
  logic [CW-1:0]   fill;
  logic [CW-1:0]   count_lim;
  logic [CLW-1:0]  tc_ext;
  logic            step_last;
  logic            load_ok;
  logic            sample_go;
  acf_ctl_t        ctl_next;

  always_comb begin
    tc_ext    = CLW'(tap_count);
    count_lim = (tc_ext > CLW'(MAX_TAPS)) ? FULL : CW'(tc_ext);
  end

  assign load_ok   = in_accept && (req_type == REQ_LOAD) &&
                     (32'(tap_index) < 32'(MAX_TAPS));
  assign sample_go = in_accept && (req_type == REQ_SAMPLE);
  assign step_last = (count_lim == '0) || (k == count_lim - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idle       = 1'b0;
    ctl_next   = '{beat: 1'b0, act: 1'b0, first: 1'b0, last: 1'b0};
    unique case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (sample_go) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl_next.beat  = 1'b1;
        ctl_next.act   = (count_lim != '0) && (k < fill);
        ctl_next.first = (k == '0);
        ctl_next.last  = step_last;
        if (step_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
      pos  <= '0;
      k    <= '0;
      ctl  <= '{beat: 1'b0, act: 1'b0, first: 1'b0, last: 1'b0};
    end else begin
      ctl <= ctl_next;
      if (sample_go) begin
        pos  <= ptr;
        k    <= '0;
        ptr  <= (ptr == LAST_ADDR) ? '0 : ptr + AW'(1);
        fill <= (fill == FULL) ? FULL : fill + CW'(1);
      end else if (state == ST_RUN) begin
        k   <= k + CW'(1);
        pos <= (pos == '0) ? LAST_ADDR : pos - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_go) begin
      hist[ptr] <= sample_in;
    end
    x_rd <= hist[pos];
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      taps[AW'(tap_index)] <= tap_value;
    end
    tap_rd <= taps[k[AW-1:0]];
  end

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && count_lim != '0) |-> (k < count_lim))
    else $error("tap walk ran past the tap count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("history fill count exceeds depth");

endmodule

@@ hdl/acf_mac.sv @@
// Shared term unit: per-tap multiply, divide by unity, gain, saturate, accumulate.
// Depends on acf_pkg; takes steps from acf_seq and holds the finished sum.
module acf_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [acf_pkg::SAMPLE_W-1:0] x_rd,
  input  logic signed [acf_pkg::SAMPLE_W-1:0] tap_rd,
  input  logic signed [acf_pkg::SAMPLE_W-1:0] gain,
  input  acf_pkg::acf_ctl_t                   ctl_in,
  input  logic                                res_take,
  output logic                                res_valid,
  output logic signed [acf_pkg::SAMPLE_W-1:0] res
);
  import acf_pkg::*;

  localparam int PW = 2 * SAMPLE_W;
  localparam int AW = PW - 1;
  localparam int QW = SAMPLE_W + 1;

  acf_ctl_t c1, c2, c3, c4;

  logic signed [SAMPLE_W-1:0] x_eff;
  logic signed [SAMPLE_W-1:0] tap_eff;
  logic signed [PW-1:0]       p1;
  logic [AW-1:0]              a_abs;
  logic [QW-1:0]              q0, r, q;
  logic                       neg1;
  logic signed [SAMPLE_W-1:0] t1_next, t1;
  logic signed [PW-1:0]       p2, p2_adj, p2_sh;
  logic signed [SAMPLE_W-1:0] t2_next, t2;
  logic signed [SAMPLE_W-1:0] acc, sum_next;

  assign x_eff   = ctl_in.act ? x_rd : '0;
  assign tap_eff = ctl_in.act ? tap_rd : '0;

  // Divide the magnitude by 2^15-1: a = q0*(2^15-1) + (q0 + low bits).
  always_comb begin
    neg1  = p1[PW-1];
    a_abs = neg1 ? AW'(-p1) : AW'(p1);
    q0    = QW'(a_abs[AW-1:UNITY_SHIFT]);
    r     = q0 + QW'(a_abs[UNITY_SHIFT-1:0]);
    if (r >= QW'(2 * UNITY)) begin
      q = q0 + QW'(2);
    end else if (r >= QW'(UNITY)) begin
      q = q0 + QW'(1);
    end else begin
      q = q0;
    end
    if (neg1) begin
      t1_next = (q > QW'(32768)) ? SAMPLE_MIN : SAMPLE_W'(QW'(0) - q);
    end else begin
      t1_next = (q > QW'(32767)) ? SAMPLE_MAX : SAMPLE_W'(q);
    end
  end

  always_comb begin
    p2_adj = p2[PW-1] ? p2 + PW'((1 << GAIN_FRAC) - 1) : p2;
    p2_sh  = p2_adj >>> GAIN_FRAC;
    if (p2_sh > PW'(SAMPLE_MAX)) begin
      t2_next = SAMPLE_MAX;
    end else if (p2_sh < PW'(SAMPLE_MIN)) begin
      t2_next = SAMPLE_MIN;
    end else begin
      t2_next = SAMPLE_W'(p2_sh);
    end
  end

  assign sum_next = c4.first ? t2 : acc + t2;

  always_ff @(posedge clk) begin
    p1  <= x_eff * tap_eff;
    t1  <= t1_next;
    p2  <= t1 * gain;
    t2  <= t2_next;
    if (c4.beat) begin
      acc <= sum_next;
    end
    if (c4.beat && c4.last) begin
      res <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1        <= '{beat: 1'b0, act: 1'b0, first: 1'b0, last: 1'b0};
      c2        <= '{beat: 1'b0, act: 1'b0, first: 1'b0, last: 1'b0};
      c3        <= '{beat: 1'b0, act: 1'b0, first: 1'b0, last: 1'b0};
      c4        <= '{beat: 1'b0, act: 1'b0, first: 1'b0, last: 1'b0};
      res_valid <= 1'b0;
    end else begin
      c1 <= ctl_in;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      if (c4.beat && c4.last) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("pending result changed before it was taken");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (c4.beat && c4.last) |-> !res_valid)
    else $error("new sum finished while the previous one was pending");

endmodule

@@ test/tb_audio_convolution_fir.sv @@
`timescale 1ns / 100ps
// Testbench for audio_convolution_fir: streams tap loads and audio samples,
// predicts every convolved sample and checks each output beat in order.
// Depends on acf_pkg and the audio_convolution_fir RTL only.
module tb_audio_convolution_fir;
  import acf_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int TAIL_CYCLES      = 64;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int LONG_TAPS        = 100;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [47:0]            s_tdata   = '0;
  logic [0:0]             s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [15:0]            m_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic signed [SAMPLE_W-1:0]   hist_mem [ACF_MAX_TAPS];
  logic signed [SAMPLE_W-1:0]   tap_mem [ACF_MAX_TAPS];
  bit                           tap_known [ACF_MAX_TAPS];
  int                           hist_ptr;
  logic [TAP_COUNT_W-1:0]       taps_used;
  logic signed [CFG_DATA_W-1:0] gain_reg;
  logic [SAMPLE_W-1:0]          expected_out [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int sink_hold      = 0;
  bit hold_request   = 1'b0;
  bit hold_done      = 1'b0;
  int idle_cycles    = 0;
  int errors         = 0;

  always #5 clk = ~clk;

  audio_convolution_fir u_top (.*);

  function automatic longint clamp16(longint v);
    if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
    if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
    return v;
  endfunction

  function automatic longint tap_term(longint x, longint tap, longint gain);
    longint scaled;
    scaled = clamp16((x * tap) / UNITY);
    return clamp16((scaled * gain) / (1 << GAIN_FRAC));
  endfunction

  function automatic logic [SAMPLE_W-1:0] convolve_sample(logic signed [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] acc;
    int count;
    int pos;
    acc = '0;
    hist_mem[hist_ptr] = x;
    count = (taps_used > ACF_MAX_TAPS) ? ACF_MAX_TAPS : int'(taps_used);
    for (int k = 0; k < count; k++) begin
      pos = (hist_ptr + ACF_MAX_TAPS - k) % ACF_MAX_TAPS;
      acc += SAMPLE_W'(tap_term(hist_mem[pos], tap_mem[k], gain_reg));
    end
    hist_ptr = (hist_ptr + 1) % ACF_MAX_TAPS;
    return acc;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return $urandom_range(1) ? 16'sd0 : -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Ready only changes at a rising edge, so its value at the falling edge
  // tells whether the beat is taken at the next rising edge.
  task automatic send_beat(input logic req, input logic [TAP_INDEX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] tap_val,
                           input logic signed [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {6'd0, smp, tap_val, idx};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    if (req == REQ_LOAD) begin
      tap_mem[idx]   = tap_val;
      tap_known[idx] = 1'b1;
    end else begin
      expected_out.push_back(convolve_sample(smp));
    end
  endtask

  task automatic load_tap(input logic [TAP_INDEX_W-1:0] idx,
                          input logic signed [SAMPLE_W-1:0] val);
    send_beat(REQ_LOAD, idx, val, rand_word());
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    send_beat(REQ_SAMPLE, TAP_INDEX_W'($urandom), rand_word(), x);
  endtask

  task automatic settle(input int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_out.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      CFG_TAP_COUNT: taps_used = data[TAP_COUNT_W-1:0];
      CFG_GAIN:      gain_reg = data;
      default: ;
    endcase
  endtask

  // Every tap the walk will read is loaded before the new length takes effect.
  task automatic set_filter(input int count, input logic [CFG_DATA_W-1:0] gain);
    for (int i = 0; i < count && i < ACF_MAX_TAPS; i++) begin
      if (!tap_known[i]) load_tap(TAP_INDEX_W'(i), rand_word());
    end
    settle(SETTLE_CYCLES);
    write_reg(CFG_TAP_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_GAIN, gain);
  endtask

  task automatic test_directed_extremes();
    load_tap(TAP_INDEX_W'(0), SAMPLE_MAX);
    load_tap(TAP_INDEX_W'(1), SAMPLE_MIN);
    load_tap(TAP_INDEX_W'(2), 16'sd0);
    load_tap(TAP_INDEX_W'(ACF_MAX_TAPS - 1), -16'sd1);
    set_filter(3, GAIN_RESET);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    set_filter(3, SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    set_filter(2, SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    settle(SETTLE_CYCLES);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, 16'h5a5a);
    set_filter(0, GAIN_RESET);
    send_sample(16'sd1234);
    // Zero samples push the remaining history out of a three-tap window.
    set_filter(3, GAIN_RESET);
    repeat (3) send_sample(16'sd0);
  endtask

  task automatic test_random_traffic();
    int idle_src[4]  = '{0, 79, 0, 26};
    int idle_sink[4] = '{0, 0, 79, 26};
    int n_taps;
    logic [CFG_DATA_W-1:0] gain;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_src[ph];
      sink_stall_pct = idle_sink[ph];
      for (int blk = 0; blk < 2; blk++) begin
        case ($urandom_range(7))
          0: n_taps = 0;
          1: n_taps = 1;
          2: n_taps = $urandom_range(33, 64);
          default: n_taps = $urandom_range(2, 16);
        endcase
        case ($urandom_range(5))
          0: gain = SAMPLE_MAX;
          1: gain = SAMPLE_MIN;
          2: gain = GAIN_RESET;
          3: gain = CFG_DATA_W'($urandom_range(0, 511));
          default: gain = CFG_DATA_W'($urandom);
        endcase
        set_filter(n_taps, gain);
        for (int i = 0; i < 60; i++) begin
          if ($urandom_range(3) == 0) begin
            load_tap(TAP_INDEX_W'($urandom_range(ACF_MAX_TAPS - 1)), rand_word());
          end else begin
            send_sample(rand_word());
          end
        end
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_filter(4, GAIN_RESET);
    hold_request = 1'b1;
    repeat (24) send_sample(rand_word());
    settle(0);
    repeat (8) send_sample(rand_word());
  endtask

  task automatic test_long_window();
    src_idle_pct   = 0;
    sink_stall_pct = 26;
    set_filter(LONG_TAPS, GAIN_RESET);
    repeat (4) send_sample(rand_word());
    set_filter(LONG_TAPS, SAMPLE_MIN);
    repeat (3) send_sample(rand_word());
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: sample_out %0d arrived with no beat expected", $time,
                 $signed(m_tdata));
      end else begin
        if (m_tdata !== expected_out[0]) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d, got %0d", $time,
                   $signed(expected_out[0]), $signed(m_tdata));
        end
        void'(expected_out.pop_front());
      end
    end
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      sink_hold = SINK_HOLD_CYCLES;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ACF_MAX_TAPS; i++) hist_mem[i] = '0;
    hist_ptr  = 0;
    taps_used = TAP_COUNT_RESET;
    gain_reg  = GAIN_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_random_traffic();
    test_backpressure();
    test_long_window();
    settle(TAIL_CYCLES);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/acf_pkg.sv
hdl/acf_seq.sv
hdl/acf_mac.sv
hdl/audio_convolution_fir.sv
test/tb_audio_convolution_fir.sv
